### rtl/core/gws_pkg.sv
package gws_pkg;

  // default largest half width of the window
  localparam int HALF_KERNEL_MAX_DEF = 31;

  // line length before the position wraps
  localparam int LINE_MAX = 4096;
  localparam int POS_W    = $clog2(LINE_MAX);

  // field widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int WEIGHT_WIDTH = 16;
  localparam int KH_W         = 5;
  localparam int WIDX_W       = 5;

  // half width after reset
  localparam logic [KH_W-1:0] KERNEL_HALF_RST = KH_W'(10);

  // input transaction kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_WEIGHT = 1'b1;

endpackage

### rtl/core/gws_div.sv
module gws_div #(
  parameter int DVD_W = 38,
  parameter int DVS_W = 22,
  parameter int QW    = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [QW-1:0]    quotient
);

  localparam int STEP_W = $clog2(QW + 1);

  logic [DVS_W-1:0]  rem_r;
  logic [QW-1:0]     quo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W:0]    trial;
  logic              fits;

  // restoring step: one quotient bit per cycle
  assign trial = {rem_r, quo_r[QW-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // step counter, quotient is known to stay below 2**QW
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(QW);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // partial remainder starts with the high dividend bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[QW+DVS_W-1:QW];
      quo_r <= dividend[QW-1:0];
    end else if (busy_r) begin
      rem_r <= fits ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
      quo_r <= {quo_r[QW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/gaussian_window_smoother.sv
// one result walks up to 2*kernel_half+1 taps (63 for a half width of 31)
// the shared multiply-accumulate walks the taps one a cycle, a 1-bit restoring divider follows
// a sample that releases no result and a weight write leave in_ready high; the last sample of a line
// releases up to kernel_half+1 results back to back through the same loop
// reset (rst_n low, synchronous): control state cleared, weights read as zero, kernel_half = 10
// the sample ring is not cleared; only samples of the current line are ever read
module gaussian_window_smoother #(
  parameter int HALF_KERNEL_MAX = gws_pkg::HALF_KERNEL_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_func,
  input  logic signed [gws_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic                                   in_sample_last,
  input  logic [gws_pkg::WIDX_W-1:0]             in_weight_index,
  input  logic [gws_pkg::WEIGHT_WIDTH-1:0]       in_weight_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [gws_pkg::SAMPLE_WIDTH-1:0] out_smoothed,
  output logic [gws_pkg::POS_W-1:0]              out_position,
  output logic                                   out_run_end,
  output logic                                   out_line_end,
  output logic                                   out_long_line,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gws_pkg::KH_W-1:0]               cfg_kernel_half
);

  import gws_pkg::*;

  localparam int RING_LEN = 2 * HALF_KERNEL_MAX + 2;
  localparam int RING_AW  = $clog2(RING_LEN);
  localparam int IDX_W    = RING_AW + 1;
  localparam int CNT_W    = $clog2(RING_LEN + 1);
  localparam int WT_DEPTH = HALF_KERNEL_MAX + 1;
  localparam int WT_AW    = $clog2(WT_DEPTH);
  localparam int TAP_W    = $clog2(2 * HALF_KERNEL_MAX + 2);
  localparam int PROD_W   = SAMPLE_WIDTH + WEIGHT_WIDTH + 1;
  localparam int ACC_W    = PROD_W + TAP_W;
  localparam int WSUM_W   = WEIGHT_WIDTH + TAP_W;
  localparam int QW       = SAMPLE_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MAC,
    S_DRAIN,
    S_DIV,
    S_DIVW,
    S_EMIT
  } state_t;

  state_t state_r;

  // configuration and line state
  logic [KH_W-1:0]    kh_r;
  logic [POS_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   avail_r;
  logic [RING_AW-1:0] wr_ptr_r;
  logic               ovf_r;
  logic [WT_DEPTH-1:0] wt_vld_r;

  // per transaction sequencing
  logic [POS_W-1:0]   newest_r;
  logic [CNT_W-1:0]   k_r;
  logic [CNT_W-1:0]   a_r;
  logic [CNT_W-1:0]   g_r;
  logic [CNT_W-1:0]   hi_r;
  logic               flush_r;
  logic               s1_v_r;
  logic               s2_v_r;
  logic               div_start_r;
  logic               neg_r;
  logic signed [SAMPLE_WIDTH-1:0] res_r;

  // output register
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_smoothed_r;
  logic [POS_W-1:0]               out_position_r;
  logic                           out_run_end_r;
  logic                           out_line_end_r;
  logic                           out_long_line_r;

  // memories and datapath
  logic [SAMPLE_WIDTH-1:0]        ring_mem [RING_LEN];
  logic [WEIGHT_WIDTH-1:0]        wt_mem [WT_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] ring_q_r;
  logic [WEIGHT_WIDTH-1:0]        wt_q_r;
  logic                           wt_v_q_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic [WEIGHT_WIDTH-1:0]        wp_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic [WSUM_W-1:0]              wsum_r;

  // combinational helpers
  logic               in_acc;
  logic               smp_acc;
  logic               wgt_wr;
  logic [CNT_W-1:0]   k_cfg;
  logic [CNT_W-1:0]   avail_inc;
  logic [CNT_W-1:0]   span_hi;
  logic [CNT_W-1:0]   lo_nxt;
  logic [CNT_W-1:0]   hi_nxt;
  logic [IDX_W-1:0]   idx_raw;
  logic [RING_AW-1:0] ring_idx;
  logic [WT_AW-1:0]   d_sel;
  logic [WEIGHT_WIDTH-1:0] w_eff;
  logic [ACC_W-1:0]   acc_mag;
  logic               div_done;
  logic [QW-1:0]      div_q;
  logic [POS_W:0]     pos_wide;
  logic               out_load;
  logic               last_emit;

  // handshakes
  assign in_acc    = in_valid && in_ready;
  assign smp_acc   = in_acc && (in_func == FUNC_SAMPLE);
  assign wgt_wr    = in_acc && (in_func == FUNC_WEIGHT) &&
                     (int'(in_weight_index) <= HALF_KERNEL_MAX);
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // half width clamped to HALF_KERNEL_MAX
  assign k_cfg = (int'(kh_r) > HALF_KERNEL_MAX) ? CNT_W'(HALF_KERNEL_MAX) : CNT_W'(kh_r);
  assign avail_inc = (avail_r < CNT_W'(RING_LEN)) ? avail_r + 1'b1 : avail_r;

  // tap range of the current center, clipped to the samples held
  assign span_hi = a_r + k_r;
  assign lo_nxt  = (a_r > k_r) ? a_r - k_r : '0;
  assign hi_nxt  = (span_hi >= avail_r) ? avail_r - 1'b1 : span_hi;

  // ring slot of the tap g_r steps old
  assign idx_raw  = IDX_W'(wr_ptr_r) + IDX_W'(RING_LEN - 1) - IDX_W'(g_r);
  assign ring_idx = (idx_raw >= IDX_W'(RING_LEN)) ? RING_AW'(idx_raw - IDX_W'(RING_LEN))
                                                  : idx_raw[RING_AW-1:0];
  assign d_sel    = (a_r > g_r) ? WT_AW'(a_r - g_r) : WT_AW'(g_r - a_r);
  assign w_eff    = wt_v_q_r ? wt_q_r : '0;

  // magnitude for the unsigned divider
  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  // position of the center sample, wrapped into the line
  assign pos_wide = {1'b0, newest_r}
                  + ((newest_r < POS_W'(a_r)) ? (POS_W+1)'(LINE_MAX) : '0)
                  - (POS_W+1)'(a_r);

  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign last_emit = !flush_r || (a_r == '0);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kh_r        <= KERNEL_HALF_RST;
      cnt_r       <= '0;
      avail_r     <= '0;
      wr_ptr_r    <= '0;
      ovf_r       <= 1'b0;
      wt_vld_r    <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= (state_r == S_MAC);
      s2_v_r      <= s1_v_r;
      div_start_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        kh_r <= cfg_kernel_half;
      end
      if (wgt_wr) begin
        wt_vld_r[WT_AW'(in_weight_index)] <= 1'b1;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (smp_acc) begin
            if (cnt_r == '0 && avail_r != '0) begin
              ovf_r <= 1'b1;
            end
            newest_r <= cnt_r;
            cnt_r    <= (cnt_r == POS_W'(LINE_MAX - 1)) ? '0 : cnt_r + 1'b1;
            wr_ptr_r <= (wr_ptr_r == RING_AW'(RING_LEN - 1)) ? '0 : wr_ptr_r + 1'b1;
            avail_r  <= avail_inc;
            k_r      <= k_cfg;
            flush_r  <= in_sample_last;
            if (in_sample_last) begin
              a_r     <= (k_cfg < avail_inc) ? k_cfg : avail_inc - 1'b1;
              state_r <= S_SETUP;
            end else if (k_cfg < avail_inc) begin
              a_r     <= k_cfg;
              state_r <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          g_r     <= lo_nxt;
          hi_r    <= hi_nxt;
          state_r <= S_MAC;
        end
        S_MAC: begin
          if (g_r == hi_r) begin
            state_r <= S_DRAIN;
          end else begin
            g_r <= g_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!s1_v_r && !s2_v_r) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          neg_r <= acc_r[ACC_W-1];
          if (wsum_r == '0) begin
            res_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            div_start_r <= 1'b1;
            state_r     <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            res_r   <= neg_r ? SAMPLE_WIDTH'(~div_q + 1'b1) : SAMPLE_WIDTH'(div_q);
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid_r     <= 1'b1;
            out_smoothed_r  <= res_r;
            out_position_r  <= pos_wide[POS_W-1:0];
            out_run_end_r   <= last_emit;
            out_line_end_r  <= flush_r && (a_r == '0);
            out_long_line_r <= ovf_r;
            if (!last_emit) begin
              a_r     <= a_r - 1'b1;
              state_r <= S_SETUP;
            end else begin
              if (flush_r) begin
                cnt_r   <= '0;
                avail_r <= '0;
                ovf_r   <= 1'b0;
              end
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // sample ring, read data registered
  always_ff @(posedge clk) begin
    if (smp_acc) begin
      ring_mem[wr_ptr_r] <= in_sample;
    end
    ring_q_r <= ring_mem[ring_idx];
  end

  // weight table, unwritten entries read as zero through the valid bits
  always_ff @(posedge clk) begin
    if (wgt_wr) begin
      wt_mem[WT_AW'(in_weight_index)] <= in_weight_value;
    end
    wt_q_r   <= wt_mem[d_sel];
    wt_v_q_r <= wt_vld_r[d_sel];
  end

  // shared multiply then accumulate
  always_ff @(posedge clk) begin
    prod_r <= ring_q_r * $signed({1'b0, w_eff});
    wp_r   <= w_eff;
    if (state_r == S_SETUP) begin
      acc_r  <= '0;
      wsum_r <= '0;
    end else if (s2_v_r) begin
      acc_r  <= acc_r + ACC_W'(prod_r);
      wsum_r <= wsum_r + WSUM_W'(wp_r);
    end
  end

  gws_div #(
    .DVD_W (ACC_W),
    .DVS_W (WSUM_W),
    .QW    (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (acc_mag),
    .divisor  (wsum_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid     = out_valid_r;
  assign out_smoothed  = out_smoothed_r;
  assign out_position  = out_position_r;
  assign out_run_end   = out_run_end_r;
  assign out_line_end  = out_line_end_r;
  assign out_long_line = out_long_line_r;

endmodule

### rtl/core/gws_chk.sv
module gws_chk (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    in_func,
  input logic                                    in_sample_last,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [gws_pkg::SAMPLE_WIDTH-1:0] out_smoothed,
  input logic [gws_pkg::POS_W-1:0]               out_position,
  input logic                                    out_run_end,
  input logic                                    out_line_end
);

  import gws_pkg::*;

  // the result for the final sample always closes its transaction's run
  a_line_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_end |-> out_run_end)
    else $error("line_end result without run_end");

  // a weight write never blocks the next transaction
  a_weight_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_WEIGHT) |=> in_ready)
    else $error("not ready after weight write");

  // the last sample of a line always starts a flush
  a_last_sample_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_SAMPLE) && in_sample_last |=> !in_ready)
    else $error("last sample did not start a flush");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_smoothed) &&
                                $stable(out_position) && $stable(out_run_end))
    else $error("stalled result changed");

endmodule

bind gaussian_window_smoother gws_chk u_gws_chk (.*);

### bench/smoother_checker.sv
`timescale 1ns / 1ps

module smoother_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic                                    in_func,
  input  logic signed [gws_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic                                    in_sample_last,
  input  logic [gws_pkg::WIDX_W-1:0]              in_weight_index,
  input  logic [gws_pkg::WEIGHT_WIDTH-1:0]        in_weight_value,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic signed [gws_pkg::SAMPLE_WIDTH-1:0] out_smoothed,
  input  logic [gws_pkg::POS_W-1:0]               out_position,
  input  logic                                    out_run_end,
  input  logic                                    out_line_end,
  input  logic                                    out_long_line,
  input  logic                                    cfg_valid,
  input  logic                                    cfg_ready,
  input  logic [gws_pkg::KH_W-1:0]                cfg_kernel_half,
  output int                                      mismatch_count,
  output int                                      awaited_count,
  output int                                      checked_count
);

  import gws_pkg::*;

  localparam int KMAX       = HALF_KERNEL_MAX_DEF;
  localparam int RING_DEPTH = 2 * KMAX + 2;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] smoothed;
    logic [POS_W-1:0]               position;
    logic                           run_end;
    logic                           line_end;
    logic                           long_line;
  } smoothed_point_t;

  // smoothed points predicted but not yet seen on the output
  smoothed_point_t awaited_points[$];
  smoothed_point_t want;

  // shadow of the line state
  logic signed [SAMPLE_WIDTH-1:0] line_ring [RING_DEPTH];
  logic [WEIGHT_WIDTH-1:0]        gauss_weights [KMAX+1];
  logic [POS_W-1:0]               next_pos;
  logic                           wrapped;
  int                             held;
  int                             ring_wr;
  logic [KH_W-1:0]                half_width;

  initial begin
    mismatch_count = 0;
    awaited_count  = 0;
    checked_count  = 0;
  end

  // edge-normalized weighted mean around the sample that is age steps old
  function automatic logic signed [SAMPLE_WIDTH-1:0] weighted_mean(int age, int k);
    longint acc, wsum, s, w;
    int j, g, d, idx;
    acc  = 0;
    wsum = 0;
    for (j = -k; j <= k; j++) begin
      g = age - j;
      d = (j < 0) ? -j : j;
      if (g >= 0 && g < held) begin
        idx  = (ring_wr + RING_DEPTH - 1 - g) % RING_DEPTH;
        s    = line_ring[idx];
        w    = gauss_weights[d];
        acc  += s * w;
        wsum += w;
      end
    end
    if (wsum == 0) return '0;
    return SAMPLE_WIDTH'(acc / wsum);
  endfunction

  function automatic smoothed_point_t make_point(int age, int k, logic [POS_W-1:0] newest,
                                                 logic run_end, logic line_end);
    smoothed_point_t p;
    p.smoothed  = weighted_mean(age, k);
    p.position  = newest - POS_W'(age);
    p.run_end   = run_end;
    p.line_end  = line_end;
    p.long_line = wrapped;
    return p;
  endfunction

  // one sample transaction: store it and queue what it releases
  task automatic predict_sample(logic signed [SAMPLE_WIDTH-1:0] s, logic last);
    int k, a;
    logic [POS_W-1:0] newest;
    k = (half_width > KMAX) ? KMAX : half_width;
    if (next_pos == 0 && held > 0) wrapped = 1'b1;
    newest   = next_pos;
    next_pos = next_pos + 1'b1;
    line_ring[ring_wr] = s;
    ring_wr = (ring_wr + 1) % RING_DEPTH;
    if (held < RING_DEPTH) held++;
    if (last) begin
      // flush everything still owed, oldest first
      for (a = (k < held) ? k : held - 1; a >= 0; a--)
        awaited_points.push_back(make_point(a, k, newest, a == 0, a == 0));
      next_pos = '0;
      held     = 0;
      wrapped  = 1'b0;
    end else if (k < held) begin
      awaited_points.push_back(make_point(k, k, newest, 1'b1, 1'b0));
    end
  endtask

  task automatic report_field(string field, int expected_val, int actual_val);
    if (expected_val != actual_val) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, field, expected_val, actual_val);
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_points.delete();
      for (int i = 0; i <= KMAX; i++) gauss_weights[i] = '0;
      next_pos   = '0;
      wrapped    = 1'b0;
      held       = 0;
      ring_wr    = 0;
      half_width = KERNEL_HALF_RST;
    end else begin
      if (cfg_valid && cfg_ready) half_width = cfg_kernel_half;
      // input transaction
      if (in_valid && in_ready) begin
        if (in_func == FUNC_WEIGHT) gauss_weights[in_weight_index] = in_weight_value;
        else predict_sample(in_sample, in_sample_last);
      end
      // output transaction
      if (out_valid && out_ready) begin
        checked_count++;
        if (awaited_points.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual smoothed %0d position %0d",
                   $time, out_smoothed, out_position);
        end else begin
          want = awaited_points.pop_front();
          report_field("smoothed", want.smoothed, out_smoothed);
          report_field("position", want.position, out_position);
          report_field("run_end", want.run_end, out_run_end);
          report_field("line_end", want.line_end, out_line_end);
          report_field("long_line", want.long_line, out_long_line);
        end
      end
    end
    awaited_count = awaited_points.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gws_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int SETTLE_IDLE  = 150;
  localparam int SETTLE_END   = 4000;

  logic                           clk             = 1'b0;
  logic                           rst_n           = 1'b0;
  logic                           in_valid        = 1'b0;
  logic                           in_ready;
  logic                           in_func         = FUNC_SAMPLE;
  logic signed [SAMPLE_WIDTH-1:0] in_sample       = '0;
  logic                           in_sample_last  = 1'b0;
  logic [WIDX_W-1:0]              in_weight_index = '0;
  logic [WEIGHT_WIDTH-1:0]        in_weight_value = '0;
  logic                           out_valid;
  logic                           out_ready       = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] out_smoothed;
  logic [POS_W-1:0]               out_position;
  logic                           out_run_end;
  logic                           out_line_end;
  logic                           out_long_line;
  logic                           cfg_valid       = 1'b0;
  logic                           cfg_ready;
  logic [KH_W-1:0]                cfg_kernel_half = '0;

  int mismatch_count;
  int awaited_count;
  int checked_count;

  int send_idle_pct = 24;
  int recv_idle_pct = 83;
  int hold_req      = 0;
  int hold_left     = 0;
  int sample_txns   = 0;
  int weight_txns   = 0;

  always #(HALF_PERIOD) clk = ~clk;

  gaussian_window_smoother DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_sample       (in_sample),
    .in_sample_last  (in_sample_last),
    .in_weight_index (in_weight_index),
    .in_weight_value (in_weight_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_smoothed    (out_smoothed),
    .out_position    (out_position),
    .out_run_end     (out_run_end),
    .out_line_end    (out_line_end),
    .out_long_line   (out_long_line),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_kernel_half (cfg_kernel_half)
  );

  smoother_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_sample       (in_sample),
    .in_sample_last  (in_sample_last),
    .in_weight_index (in_weight_index),
    .in_weight_value (in_weight_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_smoothed    (out_smoothed),
    .out_position    (out_position),
    .out_run_end     (out_run_end),
    .out_line_end    (out_line_end),
    .out_long_line   (out_long_line),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_kernel_half (cfg_kernel_half),
    .mismatch_count  (mismatch_count),
    .awaited_count   (awaited_count),
    .checked_count   (checked_count)
  );

  // receiver: random back-pressure plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(logic func, logic signed [SAMPLE_WIDTH-1:0] s, logic last,
                           logic [WIDX_W-1:0] widx, logic [WEIGHT_WIDTH-1:0] wval);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_func         <= func;
    in_sample       <= s;
    in_sample_last  <= last;
    in_weight_index <= widx;
    in_weight_value <= wval;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (func == FUNC_WEIGHT) weight_txns++;
    else sample_txns++;
  endtask

  task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] s, logic last);
    send_item(FUNC_SAMPLE, s, last, WIDX_W'($urandom), WEIGHT_WIDTH'($urandom));
  endtask

  task automatic send_weight(logic [WIDX_W-1:0] widx, logic [WEIGHT_WIDTH-1:0] wval);
    send_item(FUNC_WEIGHT, SAMPLE_WIDTH'($urandom), 1'($urandom), widx, wval);
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return SAMPLE_WIDTH'($urandom_range(0, 600)) - 16'sd300;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_WIDTH-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return WEIGHT_WIDTH'($urandom);
    endcase
  endfunction

  // stop offering, wait out every awaited result and the block's tail work
  task automatic drain_block(int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_half_width(logic [KH_W-1:0] k);
    drain_block(SETTLE_IDLE);
    cfg_kernel_half <= k;
    cfg_valid       <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // well-formed line of random length, with some weight writes mixed in
  task automatic random_line(int max_len);
    int len;
    len = $urandom_range(1, max_len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 12) send_weight(WIDX_W'($urandom), pick_weight());
      send_sample(pick_sample(), i == len - 1);
    end
  endtask

  task automatic random_phase(int items_goal, int max_len);
    int stop_at;
    stop_at = sample_txns + weight_txns + items_goal;
    while (sample_txns + weight_txns < stop_at) random_line(max_len);
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero weight sum on a short line at the reset half width
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd200, 1'b1);

    // half width 0; weight write ignores its sample_last
    send_item(FUNC_WEIGHT, 16'sh7fff, 1'b1, WIDX_W'(0), '1);
    write_half_width(KH_W'(0));
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);

    // half width 31 on a line far shorter than the window
    write_half_width(KH_W'(31));
    send_weight('1, WEIGHT_WIDTH'(1));
    send_weight(WIDX_W'(1), WEIGHT_WIDTH'(40000));
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd1000, 1'b0);
    send_sample(16'sd12345, 1'b1);

    // half width changed within a line
    write_half_width(KH_W'(2));
    send_sample(16'sd300, 1'b0);
    send_sample(-16'sd300, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd8, 1'b0);
    write_half_width(KH_W'(5));
    send_sample(16'sd9, 1'b0);
    send_sample(16'sd10, 1'b1);

    // sender mostly busy, receiver mostly stalled, with one long hold-off
    write_half_width(KH_W'($urandom_range(1, 8)));
    hold_req = 700;
    random_phase(65, 20);

    // sender mostly idle, widest window
    write_half_width(KH_W'(31));
    send_idle_pct = 83;
    recv_idle_pct = 24;
    random_phase(65, 45);

    // no idling at all
    write_half_width(KH_W'($urandom_range(0, 31)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(65, 30);

    drain_block(SETTLE_END);
    $display("covered %0d sample and %0d weight transactions, %0d results checked,",
             sample_txns, weight_txns, checked_count);
    $display("half widths 0 to 31, short lines, a mid-line width change and a long stall");
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(100_000_000);
    $display("timeout with %0d results still awaited", awaited_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### gaussian_window_smoother.f
rtl/core/gws_pkg.sv
rtl/core/gws_div.sv
rtl/core/gaussian_window_smoother.sv
rtl/core/gws_chk.sv
bench/smoother_checker.sv
bench/testbench.sv
